>>> sv/priority_ready_queue_macros.svh
// ----------------------------------------------------------------------------
// Priority ready queue assertion macros
// Shared concurrent assertion forms for the priority ready queue RTL.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

`define PRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("priority ready queue: same-cycle check failed");

`define PRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("priority ready queue: next-cycle check failed");

`else

`define PRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/prq_pkg.sv
// ----------------------------------------------------------------------------
// Priority ready queue package
// Word types, request and status codes, and the cell-to-cell structs.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP  = 2'd2;
    localparam logic [1:0] REQ_SELECT  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] thread_id;
        logic       has_priority;
        logic [7:0] priority_req;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] selected_id;
        logic       selected_valid;
    } t_out_word;

    typedef struct packed {
        logic       valid;
        logic [7:0] id;
        logic [7:0] prio;
    } t_entry;

    typedef struct packed {
        logic       enq;
        logic       remove;
        logic [7:0] id;
        logic [7:0] prio;
    } t_bcast;

    typedef struct packed {
        logic       tok;
        logic       seen;
        logic       best_valid;
        logic [7:0] best_id;
        logic [7:0] best_prio;
    } t_carry;

endpackage

>>> sv/prq_cell.sv
// ----------------------------------------------------------------------------
// Priority ready queue cell
// Holds one queue entry and processes the sweep token as it passes by.
// ----------------------------------------------------------------------------
module prq_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prq_pkg::t_bcast i_bc,
    input  logic            i_prev_valid,
    input  prq_pkg::t_entry i_next,
    output prq_pkg::t_entry o_entry,
    input  prq_pkg::t_carry i_carry,
    output prq_pkg::t_carry o_carry
);

    logic       r_valid;
    logic [7:0] r_id;
    logic [7:0] r_prio;
    logic       r_tok;
    logic       r_seen;
    logic       r_best_valid;
    logic [7:0] r_best_id;
    logic [7:0] r_best_prio;

    logic w_match;
    logic w_seen;
    logic w_better;

    assign w_match  = r_valid && (r_id == i_bc.id);
    assign w_seen   = r_seen || w_match;
    assign w_better = r_valid && (!r_best_valid || (r_prio < r_best_prio));

    assign o_entry = '{valid: r_valid, id: r_id, prio: r_prio};

    assign o_carry.tok        = r_tok;
    assign o_carry.seen       = w_seen;
    assign o_carry.best_valid = r_best_valid || w_better;
    assign o_carry.best_id    = w_better ? r_id : r_best_id;
    assign o_carry.best_prio  = w_better ? r_prio : r_best_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_carry.tok;
            if (r_tok && i_bc.remove && w_seen) begin
                r_valid <= i_next.valid;
            end else if (i_bc.enq && !r_valid && i_prev_valid) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seen       <= i_carry.seen;
        r_best_valid <= i_carry.best_valid;
        r_best_id    <= i_carry.best_id;
        r_best_prio  <= i_carry.best_prio;
        if (r_tok && i_bc.remove && w_seen) begin
            r_id   <= i_next.id;
            r_prio <= i_next.prio;
        end else if (i_bc.enq && !r_valid && i_prev_valid) begin
            r_id   <= i_bc.id;
            r_prio <= i_bc.prio;
        end
    end

endmodule

>>> sv/priority_ready_queue.sv
// ----------------------------------------------------------------------------
// Priority ready queue
// Thread ids in arrival order with priorities, kept in a chain of cells.
//
//   Channel   Signals                          Direction  Content
//   in        i_in_valid, o_in_ready, i_in     to block   request word
//   out       o_out_valid, i_out_ready, o_out  from block result word
//   cfg       i_cfg_valid, o_cfg_ready, i_cfg_data
//                                              to block   default priority
//
// The block takes one word at a time. An enqueue fills the first free
// cell as it is accepted. Remove, lookup and select send a token down
// the chain one cell per cycle, shifting entries and carrying the
// running match flag and minimum. Reset is synchronous and empties
// the queue. A stalled output holds the block before a new word.
// ----------------------------------------------------------------------------
`include "priority_ready_queue_macros.svh"

module priority_ready_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  prq_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output prq_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [7:0]         r_dflt_prio;
    logic [1:0]         r_op;
    logic [7:0]         r_req_id;
    prq_pkg::t_carry    r_fin;
    prq_pkg::t_out_word r_res;
    prq_pkg::t_out_word n_res;
    prq_pkg::t_out_word r_out;
    logic               r_out_valid;
    logic               n_out_valid;

    logic               w_accept;
    logic               w_is_enq;
    logic               w_full;
    prq_pkg::t_bcast    w_bc;
    prq_pkg::t_entry    w_ent [QUEUE_DEPTH+1];
    prq_pkg::t_carry    w_carry [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] w_vld;
    logic [QUEUE_DEPTH:0]   w_tok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_is_enq = (i_in.req_type == prq_pkg::REQ_ENQUEUE);
    assign w_full   = w_vld[QUEUE_DEPTH-1];

    assign w_bc.enq    = w_accept && w_is_enq;
    assign w_bc.remove = (r_op == prq_pkg::REQ_REMOVE);
    assign w_bc.id     = w_accept ? i_in.thread_id : r_req_id;
    assign w_bc.prio   = i_in.has_priority ? i_in.priority_req : r_dflt_prio;

    assign w_carry[0] = '{tok: w_accept && !w_is_enq, seen: 1'b0, best_valid: 1'b0,
                          best_id: 8'd0, best_prio: 8'd0};
    assign w_ent[QUEUE_DEPTH] = '0;
    assign w_tok[QUEUE_DEPTH] = w_carry[QUEUE_DEPTH].tok;

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic w_prev_valid;

        if (gi == 0) begin : g_head
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_valid = w_vld[gi-1];
        end

        prq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_bc         (w_bc),
            .i_prev_valid (w_prev_valid),
            .i_next       (w_ent[gi+1]),
            .o_entry      (w_ent[gi]),
            .i_carry      (w_carry[gi]),
            .o_carry      (w_carry[gi+1])
        );

        assign w_vld[gi] = w_ent[gi].valid;
        assign w_tok[gi] = w_carry[gi].tok;
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_enq) begin
                        n_res   = '{status: w_full ? prq_pkg::ST_FULL : prq_pkg::ST_OK,
                                    found: 1'b0, selected_id: 8'd0, selected_valid: 1'b0};
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                if (r_fin.tok) begin
                    n_res = '{status: prq_pkg::ST_OK, found: 1'b0,
                              selected_id: 8'd0, selected_valid: 1'b0};
                    unique case (r_op)
                        prq_pkg::REQ_REMOVE: begin
                            if (!r_fin.seen) begin
                                n_res.status = prq_pkg::ST_NOT_FOUND;
                            end
                        end
                        prq_pkg::REQ_LOOKUP: begin
                            n_res.found = r_fin.seen;
                        end
                        default: begin
                            if (r_fin.best_valid) begin
                                n_res.selected_id    = r_fin.best_id;
                                n_res.selected_valid = 1'b1;
                            end else begin
                                n_res.status = prq_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dflt_prio <= 8'd0;
            r_op        <= prq_pkg::REQ_ENQUEUE;
            r_fin       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fin       <= w_carry[QUEUE_DEPTH];
            if (i_cfg_valid && o_cfg_ready) begin
                r_dflt_prio <= i_cfg_data;
            end
            if (w_accept) begin
                r_op <= i_in.req_type;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_accept) begin
            r_req_id <= i_in.thread_id;
        end
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out <= r_res;
        end
    end

    `PRQ_ASSERT_IMP(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_tok))
    `PRQ_ASSERT_IMP(a_dense_prefix, i_clk, i_rst_n, 1'b1, ((w_vld >> 1) & ~w_vld) == '0)
    `PRQ_ASSERT_IMP(a_done_no_token, i_clk, i_rst_n, r_state == S_DONE, w_tok == '0)
    `PRQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != S_IDLE)

endmodule
